FILE: design/lcf_pkg.sv
// Shared types and constants of the linear convolution FIR block.
package lcf_pkg;

    localparam int VAL_W   = 16;  // sample and coefficient width
    localparam int IDX_W   = 5;   // tap index field width
    localparam int CNT_W   = 6;   // tap count register width
    localparam int PROD_W  = 32;  // width of one product
    localparam int ACC_W   = 37;  // width of the exact sum
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 40;

    localparam logic [CNT_W-1:0] TAP_COUNT_RST = 6'd32;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN1,
        S_DRAIN2,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_coef;     // write coefficient at the input tap index
        logic shift_sample;  // push the input sample into the delay line
        logic shift_zero;    // push a zero sample into the delay line
        logic clear_line;    // zero the whole delay line
        logic acc_clear;     // start a new sum
        logic mac_step;      // read one tap and rotate the delay line
        logic mac_use;       // this tap is in use and joins the sum
        logic out_load;      // move the sum into the output register
        logic out_last;      // mark of the result being loaded
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;      // output register can take a word this cycle
    } t_dp_status;

endpackage

FILE: design/lcf_datapath.sv
// Datapath: delay line, coefficient memory, multiply-accumulate and output register.
module lcf_datapath #(
    parameter int TAPS = 32,
    parameter int AW   = 5
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lcf_pkg::t_dp_cmd                  i_cmd,
    input  logic [AW-1:0]                     i_mac_addr,
    input  logic [lcf_pkg::IDX_W-1:0]         i_tap_index,
    input  logic signed [lcf_pkg::VAL_W-1:0]  i_value,
    input  logic                              i_m_tready,
    output lcf_pkg::t_dp_status               o_status,
    output logic                              o_out_valid,
    output logic signed [lcf_pkg::ACC_W-1:0]  o_filtered,
    output logic                              o_out_last
);

    logic signed [lcf_pkg::VAL_W-1:0]  r_coef_mem [TAPS];
    logic signed [lcf_pkg::VAL_W-1:0]  r_dl [TAPS];
    logic signed [lcf_pkg::VAL_W-1:0]  r_coef;
    logic signed [lcf_pkg::VAL_W-1:0]  r_samp;
    logic signed [lcf_pkg::PROD_W-1:0] r_prod;
    logic signed [lcf_pkg::ACC_W-1:0]  r_acc;
    logic                              r_v1;
    logic                              r_v2;
    logic                              r_out_valid;
    logic signed [lcf_pkg::ACC_W-1:0]  r_filtered;
    logic                              r_out_last;
    logic signed [lcf_pkg::ACC_W-1:0]  n_acc;

    // coefficient memory, one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_coef) begin
            r_coef_mem[AW'(i_tap_index)] <= i_value;
        end
        if (i_cmd.mac_step) begin
            r_coef <= r_coef_mem[i_mac_addr];
        end
    end

    // delay line; a full rotation during the sum leaves it as it was
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_line) begin
            for (int i = 0; i < TAPS; i++) begin
                r_dl[i] <= '0;
            end
        end else if (i_cmd.shift_sample || i_cmd.shift_zero) begin
            r_dl[0] <= i_cmd.shift_sample ? i_value : '0;
            for (int i = 1; i < TAPS; i++) begin
                r_dl[i] <= r_dl[i-1];
            end
        end else if (i_cmd.mac_step) begin
            for (int i = 0; i < TAPS; i++) begin
                r_dl[i] <= r_dl[(i + 1) % TAPS];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mac_step) begin
            r_samp <= r_dl[0];
        end
        r_prod <= r_coef * r_samp;
    end

    always_comb begin
        n_acc = r_acc;
        if (i_cmd.acc_clear) begin
            n_acc = '0;
        end else if (r_v2) begin
            n_acc = r_acc + lcf_pkg::ACC_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.mac_step && i_cmd.mac_use;
            r_v2 <= r_v1;
        end
    end

    // output register parts the sum from the master side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_filtered <= r_acc;
            r_out_last <= i_cmd.out_last;
        end
    end

    assign o_status.out_free = !r_out_valid || i_m_tready;
    assign o_out_valid = r_out_valid;
    assign o_filtered  = r_filtered;
    assign o_out_last  = r_out_last;

endmodule

FILE: design/lcf_ctrl.sv
// Controller: tap count register and the sequencer of loads, sums and the frame tail.
module lcf_ctrl #(
    parameter int TAPS = 32,
    parameter int AW   = 5
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [lcf_pkg::CNT_W-1:0] i_cfg_wr_data,
    input  logic                      i_s_tvalid,
    input  logic                      i_opcode,
    input  logic                      i_last,
    input  logic [lcf_pkg::IDX_W-1:0] i_tap_index,
    output logic                      o_s_tready,
    input  lcf_pkg::t_dp_status       i_status,
    output lcf_pkg::t_dp_cmd          o_cmd,
    output logic [AW-1:0]             o_mac_addr
);

    localparam logic [lcf_pkg::CNT_W-1:0] TAPS_C = lcf_pkg::CNT_W'(TAPS);
    localparam logic [AW-1:0]             K_LAST = AW'(TAPS - 1);

    lcf_pkg::t_state           r_state, n_state;
    logic [lcf_pkg::CNT_W-1:0] r_tap_count;
    logic [AW-1:0]             r_k, n_k;
    logic [lcf_pkg::CNT_W-1:0] r_tail, n_tail;
    logic                      r_in_tail, n_in_tail;
    logic [lcf_pkg::CNT_W-1:0] taps_used;
    logic                      s_accept;

    always_comb begin
        if (r_tap_count == '0) begin
            taps_used = lcf_pkg::CNT_W'(1);
        end else if (r_tap_count > TAPS_C) begin
            taps_used = TAPS_C;
        end else begin
            taps_used = r_tap_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= lcf_pkg::TAP_COUNT_RST;
        end else if (i_cfg_wr_en) begin
            r_tap_count <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lcf_pkg::S_IDLE;
            r_k       <= '0;
            r_tail    <= '0;
            r_in_tail <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_k       <= n_k;
            r_tail    <= n_tail;
            r_in_tail <= n_in_tail;
        end
    end

    assign s_accept   = i_s_tvalid && (r_state == lcf_pkg::S_IDLE);
    assign o_mac_addr = r_k;

    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        n_tail     = r_tail;
        n_in_tail  = r_in_tail;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            lcf_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (s_accept) begin
                    if (i_opcode == lcf_pkg::OP_LOAD) begin
                        o_cmd.load_coef = lcf_pkg::CNT_W'(i_tap_index) < TAPS_C;
                    end else begin
                        o_cmd.shift_sample = 1'b1;
                        o_cmd.acc_clear    = 1'b1;
                        n_k       = '0;
                        n_tail    = i_last ? taps_used : '0;
                        n_in_tail = 1'b0;
                        n_state   = lcf_pkg::S_MAC;
                    end
                end
            end
            lcf_pkg::S_MAC: begin
                o_cmd.mac_step = 1'b1;
                o_cmd.mac_use  = lcf_pkg::CNT_W'(r_k) < taps_used;
                n_k = r_k + AW'(1);
                if (r_k == K_LAST) begin
                    n_k     = '0;
                    n_state = lcf_pkg::S_DRAIN1;
                end
            end
            lcf_pkg::S_DRAIN1: begin
                n_state = lcf_pkg::S_DRAIN2;
            end
            lcf_pkg::S_DRAIN2: begin
                n_state = lcf_pkg::S_OUT;
            end
            lcf_pkg::S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = r_in_tail && (r_tail == '0);
                    if (r_tail != '0) begin
                        // next tail result: push a zero and sum again
                        o_cmd.shift_zero = 1'b1;
                        o_cmd.acc_clear  = 1'b1;
                        n_tail    = r_tail - lcf_pkg::CNT_W'(1);
                        n_in_tail = 1'b1;
                        n_k       = '0;
                        n_state   = lcf_pkg::S_MAC;
                    end else begin
                        o_cmd.clear_line = r_in_tail;
                        n_in_tail = 1'b0;
                        n_state   = lcf_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = lcf_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/linear_convolution_fir_top.sv
// A load word goes straight into the coefficient memory; the slave side stays open. A sample
// word's result runs the tap loop, S_DRAIN1 and S_DRAIN2, then enters the output register; each
// tail result after a last sample runs them again; the next word is taken in the cycle after the
// last result of a word enters that register. One shared multiply-accumulate steps through the
// coefficient memory port once per tap, plus two pipeline stages. Reset is synchronous, active low:
// control state and the delay line clear, tap_count returns to 32, coefficients stay unwritten.
module linear_convolution_fir_top #(
    parameter int TAPS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [lcf_pkg::CNT_W-1:0]    i_cfg_wr_data,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [lcf_pkg::S_DATA_W-1:0] i_s_tdata,  // tap_index[4:0], value[20:5], zero[23:21]
    input  logic                         i_s_tuser,  // opcode
    input  logic                         i_s_tlast,  // last_sample
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [lcf_pkg::M_DATA_W-1:0] o_m_tdata,  // filtered[36:0], zero[39:37]
    output logic                         o_m_tlast   // last_of_frame
);

    localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1;

    lcf_pkg::t_dp_cmd                 cmd;
    lcf_pkg::t_dp_status              status;
    logic [AW-1:0]                    mac_addr;
    logic signed [lcf_pkg::ACC_W-1:0] filtered;

    lcf_ctrl #(
        .TAPS (TAPS),
        .AW   (AW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .i_opcode      (i_s_tuser),
        .i_last        (i_s_tlast),
        .i_tap_index   (i_s_tdata[4:0]),
        .o_s_tready    (o_s_tready),
        .i_status      (status),
        .o_cmd         (cmd),
        .o_mac_addr    (mac_addr)
    );

    lcf_datapath #(
        .TAPS (TAPS),
        .AW   (AW)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_mac_addr  (mac_addr),
        .i_tap_index (i_s_tdata[4:0]),
        .i_value     (i_s_tdata[20:5]),
        .i_m_tready  (i_m_tready),
        .o_status    (status),
        .o_out_valid (o_m_tvalid),
        .o_filtered  (filtered),
        .o_out_last  (o_m_tlast)
    );

    assign o_m_tdata = {3'b000, filtered};

endmodule

FILE: design/lcf_checker.sv
// Port-level checker of the linear convolution FIR block, bound to the top level.
module lcf_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_cfg_wr_en,
    input logic [lcf_pkg::CNT_W-1:0]    i_cfg_wr_data,
    input logic                         i_s_tvalid,
    input logic                         o_s_tready,
    input logic [lcf_pkg::S_DATA_W-1:0] i_s_tdata,
    input logic                         i_s_tuser,
    input logic                         i_s_tlast,
    input logic                         o_m_tvalid,
    input logic                         i_m_tready,
    input logic [lcf_pkg::M_DATA_W-1:0] o_m_tdata,
    input logic                         o_m_tlast
);

    logic sample_in;

    assign sample_in = i_s_tvalid && o_s_tready && (i_s_tuser == lcf_pkg::OP_SAMPLE);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output word changed while stalled");

    // a sample word starts a sum, so the slave side closes
    a_busy_after_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sample_in |=> !o_s_tready)
        else $error("slave side open right after a sample word");

    // a result needs the whole tap loop, never the next cycle
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sample_in && !o_m_tvalid |=> !o_m_tvalid)
        else $error("result appeared one cycle after a sample word");

    // padding bits above the sum stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[39:37] == 3'b000)
        else $error("output padding bits not zero");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output word valid after reset");

endmodule

bind linear_convolution_fir_top lcf_checker u_lcf_checker (.*);
